[src/rrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rrt_pkg;

  localparam int ROW_W     = 20;
  localparam int COL_W     = 14;
  localparam int RULE_W    = 5;
  localparam int TOTAL_W   = 6;
  localparam int MAX_RULES = 32;
  localparam logic [21:0] ROW_SPAN = 22'd1048576;
  localparam logic [15:0] COL_SPAN = 16'd16384;

  // operation codes
  localparam logic [2:0] FN_ADD_RULE = 3'd0;
  localparam logic [2:0] FN_ADD_AREA = 3'd1;
  localparam logic [2:0] FN_SUB_ALL  = 3'd2;
  localparam logic [2:0] FN_QUERY    = 3'd3;
  localparam logic [2:0] FN_SUB_RULE = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_AREA = 3'd1;
  localparam logic [2:0] ST_OVERLAP  = 3'd2;
  localparam logic [2:0] ST_BAD_IDX  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // one table entry, bottom and right inclusive
  typedef struct packed {
    logic [RULE_W-1:0] rule;
    logic [ROW_W-1:0]  top;
    logic [COL_W-1:0]  left;
    logic [ROW_W-1:0]  bottom;
    logic [COL_W-1:0]  right;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic       rd_other;
    logic       scan_eval;
    logic       split_eval;
    logic       piece;
    logic       ren_wr;
    logic       add_wr;
    logic       commit;
    logic       clr_i;
    logic       set_st;
    logic [2:0] st_code;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       area_ok;
    logic       idx_bad;
    logic       overlap;
    logic       i_end;
    logic       ren_end;
    logic       over;
    logic       pend_empty;
    logic       rules_full;
    logic       table_full;
    logic       out_busy;
  } stat_t;

endpackage
`default_nettype wire

[src/rrt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module rrt_ctrl
  import rrt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_CHECK    = 12'b000000000010,
    S_SCAN_RD  = 12'b000000000100,
    S_SCAN_EV  = 12'b000000001000,
    S_ADD      = 12'b000000010000,
    S_SPLIT_RD = 12'b000000100000,
    S_SPLIT_EV = 12'b000001000000,
    S_PIECE    = 12'b000010000000,
    S_REN_RD   = 12'b000100000000,
    S_REN_WR   = 12'b001000000000,
    S_COMMIT   = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // sequencing and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.func == FN_QUERY) begin
          state_nxt = S_SCAN_RD;
        end else if (stat.func != FN_ADD_RULE && stat.func != FN_ADD_AREA &&
                     stat.func != FN_SUB_ALL && stat.func != FN_SUB_RULE) begin
          state_nxt = S_DONE;
        end else if ((stat.func == FN_ADD_AREA || stat.func == FN_SUB_RULE) &&
                     stat.idx_bad) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_BAD_IDX;
          state_nxt   = S_DONE;
        end else if (!stat.area_ok) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_BAD_AREA;
          state_nxt   = S_DONE;
        end else if (stat.func == FN_ADD_RULE || stat.func == FN_ADD_AREA) begin
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_SPLIT_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.i_end) begin
          state_nxt = (stat.func == FN_QUERY) ? S_DONE : S_ADD;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd.scan_eval = 1'b1;
        state_nxt     = S_SCAN_RD;
      end
      S_ADD: begin
        cmd.set_st = 1'b1;
        if (stat.overlap) begin
          cmd.st_code = ST_OVERLAP;
        end else if ((stat.func == FN_ADD_RULE && stat.rules_full) ||
                     stat.table_full) begin
          cmd.st_code = ST_FULL;
        end else begin
          cmd.st_code = ST_OK;
          cmd.add_wr  = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_SPLIT_RD: begin
        if (stat.i_end) begin
          if (stat.over) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_FULL;
            state_nxt   = S_DONE;
          end else begin
            cmd.clr_i = 1'b1;
            state_nxt = S_REN_RD;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SPLIT_EV;
        end
      end
      S_SPLIT_EV: begin
        cmd.split_eval = 1'b1;
        state_nxt      = S_PIECE;
      end
      S_PIECE: begin
        if (stat.pend_empty) state_nxt = S_SPLIT_RD;
        else                 cmd.piece = 1'b1;
      end
      S_REN_RD: begin
        if (stat.ren_end) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_other = 1'b1;
          state_nxt    = S_REN_WR;
        end
      end
      S_REN_WR: begin
        cmd.ren_wr = 1'b1;
        state_nxt  = S_REN_RD;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[src/rrt_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module rrt_dp
  import rrt_pkg::*;
#(
  parameter int MAX_AREAS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic [2:0]         in_func,
  input  wire logic [RULE_W-1:0]  in_rule_index,
  input  wire logic [ROW_W-1:0]   in_area_first_row,
  input  wire logic [COL_W-1:0]   in_area_first_col,
  input  wire logic [ROW_W:0]     in_area_rows,
  input  wire logic [COL_W:0]     in_area_cols,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic                    out_found,
  output logic [RULE_W-1:0]       out_result_rule,
  output logic [TOTAL_W-1:0]      out_rule_total
);

  localparam int AW = $clog2(MAX_AREAS);
  localparam int CW = $clog2(MAX_AREAS + 1);
  localparam logic [CW-1:0] AREAS_C = CW'(MAX_AREAS);

  // two banks: current table and rebuild scratch
  entry_t mem [2**(AW+1)];
  entry_t rd_q;

  // latched operation
  logic [2:0]        func_r;
  logic [RULE_W-1:0] idx_r;
  logic [ROW_W-1:0]  top_r, bot_r;
  logic [COL_W-1:0]  left_r, right_r;
  logic              area_ok_r;

  // table state
  logic                bank_r;
  logic [CW-1:0]       n_r, sn_r, i_r;
  logic [TOTAL_W-1:0]  rule_count_r;
  logic [MAX_RULES-1:0] present_r;

  // scan and split state
  logic              overlap_r, found_r, over_r;
  logic [RULE_W-1:0] res_r;
  logic [2:0]        status_r;
  entry_t            e_r;
  logic [4:0]        pend_r;

  // output beat
  logic                out_valid_r;
  logic [2:0]          out_status_r;
  logic                out_found_r;
  logic [RULE_W-1:0]   out_rule_r;
  logic [TOTAL_W-1:0]  out_total_r;

  // area end points from the input beat
  logic [ROW_W+1:0] row_end;
  logic [COL_W+1:0] col_end;
  assign row_end = {2'b00, in_area_first_row} + {1'b0, in_area_rows};
  assign col_end = {2'b00, in_area_first_col} + {1'b0, in_area_cols};

  // overlap with area and point hit on the read entry
  logic hit, qhit;
  assign hit  = rd_q.top <= bot_r && top_r <= rd_q.bottom &&
                rd_q.left <= right_r && left_r <= rd_q.right;
  assign qhit = rd_q.top <= top_r && top_r <= rd_q.bottom &&
                rd_q.left <= left_r && left_r <= rd_q.right;

  // overlap box of the latched entry
  logic [ROW_W-1:0] ot, ob;
  logic [COL_W-1:0] ol, orr;
  assign ot  = (e_r.top > top_r) ? e_r.top : top_r;
  assign ob  = (e_r.bottom < bot_r) ? e_r.bottom : bot_r;
  assign ol  = (e_r.left > left_r) ? e_r.left : left_r;
  assign orr = (e_r.right < right_r) ? e_r.right : right_r;

  // split decision for the entry just read
  logic       target;
  logic [4:0] pend_new;
  logic [ROW_W-1:0] nt, nb;
  logic [COL_W-1:0] nl, nr;
  always_comb begin
    nt = (rd_q.top > top_r) ? rd_q.top : top_r;
    nb = (rd_q.bottom < bot_r) ? rd_q.bottom : bot_r;
    nl = (rd_q.left > left_r) ? rd_q.left : left_r;
    nr = (rd_q.right < right_r) ? rd_q.right : right_r;
    target = hit && (func_r == FN_SUB_ALL || rd_q.rule == idx_r);
    if (target) begin
      pend_new = {1'b0, nr < rd_q.right, nl > rd_q.left,
                  nb < rd_q.bottom, nt > rd_q.top};
    end else begin
      pend_new = 5'b10000;
    end
  end

  // next piece: above, below, left, right, or whole copy
  entry_t     piece;
  logic [4:0] pend_clr;
  always_comb begin
    piece    = e_r;
    pend_clr = 5'b00000;
    if (pend_r[0]) begin
      piece.bottom = ot - 1'b1;
      pend_clr     = 5'b00001;
    end else if (pend_r[1]) begin
      piece.top = ob + 1'b1;
      pend_clr  = 5'b00010;
    end else if (pend_r[2]) begin
      piece.top    = ot;
      piece.bottom = ob;
      piece.right  = ol - 1'b1;
      pend_clr     = 5'b00100;
    end else if (pend_r[3]) begin
      piece.top    = ot;
      piece.bottom = ob;
      piece.left   = orr + 1'b1;
      pend_clr     = 5'b01000;
    end else begin
      pend_clr = 5'b10000;
    end
  end

  // renumbered rule: live rules below this one
  logic [MAX_RULES-1:0] below;
  logic [RULE_W-1:0]    ren_rule;
  always_comb begin
    for (int k = 0; k < MAX_RULES; k++) begin
      below[k] = (RULE_W'(k) < rd_q.rule);
    end
    ren_rule = RULE_W'($countones(present_r & below));
  end

  // write port select
  logic              wr_en;
  logic [AW:0]       wr_addr;
  entry_t            wr_data;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {bank_r, n_r[AW-1:0]};
    wr_data = '0;
    if (cmd.add_wr) begin
      wr_en        = 1'b1;
      wr_data.rule = (func_r == FN_ADD_RULE) ? rule_count_r[RULE_W-1:0] : idx_r;
      wr_data.top    = top_r;
      wr_data.left   = left_r;
      wr_data.bottom = bot_r;
      wr_data.right  = right_r;
    end else if (cmd.piece) begin
      wr_en   = (sn_r != AREAS_C);
      wr_addr = {~bank_r, sn_r[AW-1:0]};
      wr_data = piece;
    end else if (cmd.ren_wr) begin
      wr_en        = 1'b1;
      wr_addr      = {~bank_r, i_r[AW-1:0]};
      wr_data      = rd_q;
      wr_data.rule = ren_rule;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_q <= mem[{bank_r ^ cmd.rd_other, i_r[AW-1:0]}];
  end

  // operation payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= in_func;
      idx_r     <= in_rule_index;
      top_r     <= in_area_first_row;
      left_r    <= in_area_first_col;
      bot_r     <= ROW_W'(row_end - 1'b1);
      right_r   <= COL_W'(col_end - 1'b1);
      area_ok_r <= in_area_rows != '0 && in_area_cols != '0 &&
                   row_end <= ROW_SPAN && col_end <= COL_SPAN;
    end
    if (cmd.split_eval) e_r <= rd_q;
  end

  // control and table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r       <= 1'b0;
      n_r          <= '0;
      sn_r         <= '0;
      i_r          <= '0;
      rule_count_r <= '0;
      present_r    <= '0;
      overlap_r    <= 1'b0;
      found_r      <= 1'b0;
      over_r       <= 1'b0;
      res_r        <= '0;
      status_r     <= ST_OK;
      pend_r       <= '0;
    end else begin
      if (cmd.load) begin
        i_r       <= '0;
        sn_r      <= '0;
        present_r <= '0;
        overlap_r <= 1'b0;
        found_r   <= 1'b0;
        over_r    <= 1'b0;
        res_r     <= '0;
        status_r  <= ST_OK;
      end
      if (cmd.set_st) status_r <= cmd.st_code;
      if (cmd.clr_i)  i_r <= '0;
      // overlap and query scan
      if (cmd.scan_eval) begin
        i_r <= i_r + 1'b1;
        if (func_r == FN_QUERY) begin
          if (qhit && (!found_r || rd_q.rule < res_r)) begin
            found_r <= 1'b1;
            res_r   <= rd_q.rule;
          end
        end else if (hit) begin
          overlap_r <= 1'b1;
        end
      end
      if (cmd.split_eval) begin
        i_r    <= i_r + 1'b1;
        pend_r <= pend_new;
      end
      // one piece into the scratch bank
      if (cmd.piece) begin
        pend_r <= pend_r & ~pend_clr;
        if (sn_r == AREAS_C) begin
          over_r <= 1'b1;
        end else begin
          sn_r               <= sn_r + 1'b1;
          present_r[e_r.rule] <= 1'b1;
        end
      end
      if (cmd.ren_wr) i_r <= i_r + 1'b1;
      if (cmd.add_wr) begin
        n_r <= n_r + 1'b1;
        if (func_r == FN_ADD_RULE) begin
          res_r        <= rule_count_r[RULE_W-1:0];
          rule_count_r <= rule_count_r + 1'b1;
        end
      end
      if (cmd.commit) begin
        bank_r       <= ~bank_r;
        n_r          <= sn_r;
        rule_count_r <= TOTAL_W'($countones(present_r));
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_rule_r   <= res_r;
      out_total_r  <= rule_count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_result_rule = out_rule_r;
  assign out_rule_total  = out_total_r;

  // status to the controller
  always_comb begin
    stat.func       = func_r;
    stat.area_ok    = area_ok_r;
    stat.idx_bad    = {1'b0, idx_r} >= rule_count_r;
    stat.overlap    = overlap_r;
    stat.i_end      = (i_r == n_r);
    stat.ren_end    = (i_r == sn_r);
    stat.over       = over_r;
    stat.pend_empty = (pend_r == '0);
    stat.rules_full = rule_count_r >= TOTAL_W'(MAX_RULES);
    stat.table_full = n_r >= AREAS_C;
    stat.out_busy   = out_valid_r && out_stall;
  end

endmodule
`default_nettype wire

[src/rect_region_rule_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// Table of disjoint rectangles owned by dense rule numbers; add, query and
// subtract one operation at a time. The block takes one beat, then holds
// in_stall high until the result beat is loaded into the output register.
// Add and query read the stored entries one by one through the table
// memory's single read port. Subtraction reads each entry and writes its
// pieces into the scratch bank, then rewrites every resulting entry with
// its new rule number. Operations rejected for a bad index or a bad area,
// and unused function codes, finish without reading the table. No
// clearing pass after reset: a fill count marks the live entries.
module rect_region_rule_table
  import rrt_pkg::*;
#(
  parameter int MAX_AREAS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_func,
  input  wire logic [RULE_W-1:0]  in_rule_index,
  input  wire logic [ROW_W-1:0]   in_area_first_row,
  input  wire logic [COL_W-1:0]   in_area_first_col,
  input  wire logic [ROW_W:0]     in_area_rows,
  input  wire logic [COL_W:0]     in_area_cols,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic                    out_found,
  output logic [RULE_W-1:0]       out_result_rule,
  output logic [TOTAL_W-1:0]      out_rule_total
);

  cmd_t  cmd;
  stat_t stat;

  rrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrt_dp #(
    .MAX_AREAS (MAX_AREAS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_func),
    .in_rule_index     (in_rule_index),
    .in_area_first_row (in_area_first_row),
    .in_area_first_col (in_area_first_col),
    .in_area_rows      (in_area_rows),
    .in_area_cols      (in_area_cols),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_result_rule   (out_result_rule),
    .out_rule_total    (out_rule_total)
  );

  // block goes busy after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after input beat");

  // a new result only appears while an operation was in flight
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without operation");

  // rule count never exceeds the rule limit
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rule_total <= TOTAL_W'(MAX_RULES))
    else $error("rule total out of range");

  // the datapath is only loaded from the idle state
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !in_stall)
    else $error("load while busy");

endmodule
`default_nettype wire
